/* hw/rtl/kalman_cv_tracker_2d_assert.svh */
// Assertion macros for the constant-velocity tracker.
// Depends on clk_i and rst_ni in the including module.
`ifndef KALMAN_CV_TRACKER_2D_ASSERT_SVH
`define KALMAN_CV_TRACKER_2D_ASSERT_SVH
`ifndef ASSERT_OFF
`define KCV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define KCV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KCV_ASSERT(lbl, prop, msg)
`define KCV_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hw/rtl/kcv_pkg.sv */
// Types, constants and helper functions of the constant-velocity tracker.
// No dependencies.
`default_nettype none
package kcv_pkg;

  typedef enum logic [1:0] {
    ACT_INIT    = 2'd0,
    ACT_UPDATE  = 2'd1,
    ACT_PREDICT = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOAD   = 8'b0000_0010,
    S_PREP   = 8'b0000_0100,
    S_JOB    = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_DEST   = 8'b0010_0000,
    S_REPORT = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  localparam logic [1:0] CFG_MEAS_NOISE = 2'd0;
  localparam logic [1:0] CFG_PROC_NOISE = 2'd1;
  localparam logic [1:0] CFG_INIT_VAR   = 2'd2;

  localparam logic [31:0] MeasNoiseRst = 32'd655;
  localparam logic [31:0] ProcNoiseRst = 32'd65536;
  localparam logic [31:0] InitVarRst   = 32'd65536;
  localparam logic [31:0] OneQ16       = 32'h0001_0000;

  localparam logic [4:0] LoadLast   = 5'd10;
  localparam logic [4:0] ReportLast = 5'd6;
  localparam logic [4:0] DivLast    = 5'd30;
  localparam logic [4:0] DestLast   = 5'd19;
  localparam logic [3:0] JobLast    = 4'd8;
  localparam logic [2:0] DestWrStep = 3'd5;

  localparam logic signed [48:0] GainLim = 49'sh7FFF_FFFF_FFFF;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // reset contents: identity covariance, zero mean
  function automatic logic [31:0] rst_val(input logic [4:0] idx);
    logic [31:0] r;
    r = '0;
    if (!idx[4] && (idx[1:0] == idx[3:2])) begin
      r = OneQ16;
    end
    return r;
  endfunction

  // P00 P01 P10 P11 P20 P21 P30 P31 x y
  function automatic logic [4:0] load_addr(input logic [3:0] c);
    logic [4:0] r;
    if (!c[3]) begin
      r = {1'b0, c[2:1], 1'b0, c[0]};
    end else begin
      r = {3'b100, 1'b0, c[0]};
    end
    return r;
  endfunction

  // x y vx vy P00 P11
  function automatic logic [4:0] report_addr(input logic [2:0] c);
    logic [4:0] r;
    case (c)
      3'd0, 3'd1, 3'd2, 3'd3: r = {3'b100, c[1:0]};
      3'd5: r = 5'd5;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/kalman_cv_tracker_2d.sv */
// Init and predict run the state pass; update computes gains first; code 3 only reports.
// One item at a time; read-modify-write per state entry over a 1-read/1-write RAM,
// one shared 32x32 multiplier and a 1-bit-per-cycle divider for the gains.
// Reset: async active low; state reads as zero mean and identity covariance until first
// write-back, registers to their defaults.
// Depends on kcv_pkg and kalman_cv_tracker_2d_assert.svh.
`default_nettype none
`include "kalman_cv_tracker_2d_assert.svh"
module kalman_cv_tracker_2d (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic signed [31:0] meas_x_i,
  input  wire logic signed [31:0] meas_y_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] est_x_o,
  output logic signed [31:0] est_y_o,
  output logic signed [31:0] est_vx_o,
  output logic signed [31:0] est_vy_o,
  output logic signed [31:0] var_x_o,
  output logic signed [31:0] var_y_o,
  output logic             singular_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  kcv_pkg::state_e state_q, state_d;

  logic [31:0] meas_noise_q, proc_noise_q, init_var_q;
  logic [1:0]  act_q;
  logic signed [31:0] zx_q, zy_q;
  logic bank_q, fresh_q, out_vld_q, sing_q;
  logic [4:0] cnt_q;
  logic [2:0] st_q;
  logic [3:0] jb_q;

  logic [31:0] mem_q [64];
  logic [31:0] rd_raw_q;
  logic [4:0]  ra_idx_q;
  logic signed [31:0] rd_s;
  logic [4:0]  re_idx, we_idx;
  logic        mem_we;
  logic [31:0] we_data;

  logic signed [31:0] pc_q [8];
  logic signed [31:0] k_q [8];
  logic signed [31:0] m0_q, m1_q, s00_q, s01_q, s10_q, s11_q, e0_q, e1_q;
  logic signed [48:0] det_q;
  logic signed [47:0] tmp_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] mul_a, mul_b;
  logic signed [47:0] qv;
  logic signed [48:0] job_res, n_cl;
  logic [47:0] n_mag;
  logic [48:0] d_mag;
  logic [63:0] num;
  logic        ovf;
  logic [63:0] rem_q;
  logic [78:0] dv_q;
  logic [29:0] quo_q;
  logic        neg_q, ovf_q, ge;
  logic [30:0] qfin;
  logic signed [31:0] kval;
  logic signed [49:0] acc_q, rd_w, qv_w;
  logic signed [31:0] rp_q [6];
  logic signed [31:0] est_x_q, est_y_q, est_vx_q, est_vy_q, var_x_q, var_y_q;
  logic        sing_out_q;

  logic        in_acc, out_free, det_zero;
  logic [3:0]  jm1;
  logic [4:0]  slot;
  logic        is_mean, msk1, msk2, msk3, diag;
  logic [1:0]  ci, cj, ri;
  logic signed [31:0] init_val, ivs;

  assign in_stall_o  = (state_q != kcv_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign est_x_o     = est_x_q;
  assign est_y_o     = est_y_q;
  assign est_vx_o    = est_vx_q;
  assign est_vy_o    = est_vy_q;
  assign var_x_o     = var_x_q;
  assign var_y_o     = var_y_q;
  assign singular_o  = sing_out_q;

  assign rd_s     = fresh_q ? kcv_pkg::rst_val(ra_idx_q) : rd_raw_q;
  assign rd_w     = {{18{rd_s[31]}}, rd_s};
  assign qv       = prod_q[63:16];
  assign qv_w     = {{2{qv[47]}}, qv};
  assign job_res  = {tmp_q[47], tmp_q} - {qv[47], qv};
  assign det_zero = (job_res == '0);
  assign jm1      = jb_q - 4'd1;
  assign slot     = cnt_q - 5'd1;

  // gain divider set-up
  always_comb begin
    if (job_res > kcv_pkg::GainLim) begin
      n_cl = kcv_pkg::GainLim;
    end else if (job_res < -kcv_pkg::GainLim) begin
      n_cl = -kcv_pkg::GainLim;
    end else begin
      n_cl = job_res;
    end
    n_mag = n_cl[48] ? 48'(-n_cl) : n_cl[47:0];
    d_mag = det_q[48] ? 49'(-det_q) : 49'(det_q);
    num   = {n_mag, 16'b0};
    ovf   = {16'b0, num} >= {d_mag, 31'b0};
    ge    = {15'b0, rem_q} >= dv_q;
    qfin  = {quo_q, ge};
    if (ovf_q) begin
      kval = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      kval = neg_q ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin});
    end
  end

  // per-entry decode
  always_comb begin
    is_mean = cnt_q[4];
    ci      = cnt_q[3:2];
    cj      = cnt_q[1:0];
    ri      = cnt_q[3:2];
    if (is_mean) begin
      ri = cnt_q[1:0];
    end
    msk1 = is_mean ? !cnt_q[1] : !ci[1];
    msk2 = !is_mean && !cj[1];
    msk3 = !is_mean && !ci[1] && !cj[1];
    diag = !is_mean && (ci == cj);
    ivs  = init_var_q[31] ? 32'sh7FFF_FFFF : $signed(init_var_q);
    init_val = '0;
    if (is_mean) begin
      if (cnt_q[1:0] == 2'd0) begin
        init_val = zx_q;
      end else if (cnt_q[1:0] == 2'd1) begin
        init_val = zy_q;
      end
    end else if (diag) begin
      init_val = ivs;
    end
  end

  // memory addressing and multiplier operands
  always_comb begin
    re_idx  = '0;
    mem_we  = 1'b0;
    we_idx  = cnt_q;
    we_data = (kcv_pkg::action_e'(act_q) == kcv_pkg::ACT_INIT) ? init_val : kcv_pkg::sat32(acc_q);
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_q)
      kcv_pkg::S_LOAD:   re_idx = kcv_pkg::load_addr(cnt_q[3:0]);
      kcv_pkg::S_REPORT: re_idx = kcv_pkg::report_addr(cnt_q[2:0]);
      kcv_pkg::S_JOB: begin
        if (jb_q == 4'd0) begin
          mul_a = (st_q == 3'd0) ? s00_q : s01_q;
          mul_b = (st_q == 3'd0) ? s11_q : s10_q;
        end else if (!jm1[0]) begin
          mul_a = (st_q == 3'd0) ? pc_q[{jm1[2:1], 1'b0}] : pc_q[{jm1[2:1], 1'b1}];
          mul_b = (st_q == 3'd0) ? s11_q : s10_q;
        end else begin
          mul_a = (st_q == 3'd0) ? pc_q[{jm1[2:1], 1'b1}] : pc_q[{jm1[2:1], 1'b0}];
          mul_b = (st_q == 3'd0) ? s00_q : s01_q;
        end
      end
      kcv_pkg::S_DEST: begin
        case (st_q)
          3'd1: begin
            if (kcv_pkg::action_e'(act_q) == kcv_pkg::ACT_UPDATE) begin
              re_idx = {3'b000, cj};
            end else if (is_mean) begin
              re_idx = {3'b100, cnt_q[1:0] + 2'd2};
            end else begin
              re_idx = {1'b0, ci + 2'd2, cj};
            end
          end
          3'd2: begin
            if (kcv_pkg::action_e'(act_q) == kcv_pkg::ACT_UPDATE) begin
              re_idx = {3'b001, cj};
            end else begin
              re_idx = {1'b0, ci, cj + 2'd2};
            end
            mul_a = k_q[{ri, 1'b0}];
            mul_b = is_mean ? e0_q : rd_s;
          end
          3'd3: begin
            re_idx = {1'b0, ci + 2'd2, cj + 2'd2};
            mul_a  = k_q[{ri, 1'b1}];
            mul_b  = is_mean ? e1_q : rd_s;
          end
          3'd5: mem_we = 1'b1;
          default: re_idx = is_mean ? {3'b100, cnt_q[1:0]} : cnt_q;
        endcase
      end
      default: re_idx = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kcv_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (kcv_pkg::action_e'(action_i))
            kcv_pkg::ACT_UPDATE: state_d = kcv_pkg::S_LOAD;
            kcv_pkg::ACT_NONE:   state_d = kcv_pkg::S_REPORT;
            default:             state_d = kcv_pkg::S_DEST;
          endcase
        end
      end
      kcv_pkg::S_LOAD: if (cnt_q == kcv_pkg::LoadLast) state_d = kcv_pkg::S_PREP;
      kcv_pkg::S_PREP: state_d = kcv_pkg::S_JOB;
      kcv_pkg::S_JOB: begin
        if (st_q == 3'd2) begin
          if (jb_q != 4'd0) begin
            state_d = kcv_pkg::S_DIV;
          end else if (det_zero) begin
            state_d = kcv_pkg::S_REPORT;
          end
        end
      end
      kcv_pkg::S_DIV: begin
        if (cnt_q == kcv_pkg::DivLast) begin
          state_d = (jb_q == kcv_pkg::JobLast) ? kcv_pkg::S_DEST : kcv_pkg::S_JOB;
        end
      end
      kcv_pkg::S_DEST: begin
        if (st_q == kcv_pkg::DestWrStep && cnt_q == kcv_pkg::DestLast) begin
          state_d = kcv_pkg::S_REPORT;
        end
      end
      kcv_pkg::S_REPORT: if (cnt_q == kcv_pkg::ReportLast) state_d = kcv_pkg::S_DONE;
      kcv_pkg::S_DONE:   if (out_free) state_d = kcv_pkg::S_IDLE;
      default: state_d = kcv_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kcv_pkg::S_IDLE;
      cnt_q        <= '0;
      st_q         <= '0;
      jb_q         <= '0;
      bank_q       <= 1'b0;
      fresh_q      <= 1'b1;
      out_vld_q    <= 1'b0;
      meas_noise_q <= kcv_pkg::MeasNoiseRst;
      proc_noise_q <= kcv_pkg::ProcNoiseRst;
      init_var_q   <= kcv_pkg::InitVarRst;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          kcv_pkg::CFG_MEAS_NOISE: meas_noise_q <= cfg_data_i;
          kcv_pkg::CFG_PROC_NOISE: proc_noise_q <= cfg_data_i;
          kcv_pkg::CFG_INIT_VAR:   init_var_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == kcv_pkg::S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        kcv_pkg::S_IDLE: begin
          cnt_q <= '0;
          st_q  <= '0;
          jb_q  <= '0;
        end
        kcv_pkg::S_LOAD:   cnt_q <= cnt_q + 5'd1;
        kcv_pkg::S_PREP: begin
          st_q <= '0;
          jb_q <= '0;
        end
        kcv_pkg::S_JOB: begin
          cnt_q <= '0;
          st_q  <= (st_q == 3'd2) ? 3'd0 : st_q + 3'd1;
          if (st_q == 3'd2 && jb_q == 4'd0) begin
            jb_q <= 4'd1;
          end
        end
        kcv_pkg::S_DIV: begin
          if (cnt_q == kcv_pkg::DivLast) begin
            cnt_q <= '0;
            jb_q  <= jb_q + 4'd1;
            st_q  <= '0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        kcv_pkg::S_DEST: begin
          if (st_q == kcv_pkg::DestWrStep) begin
            st_q <= '0;
            if (cnt_q == kcv_pkg::DestLast) begin
              cnt_q   <= '0;
              bank_q  <= ~bank_q;
              fresh_q <= 1'b0;
            end else begin
              cnt_q <= cnt_q + 5'd1;
            end
          end else begin
            st_q <= st_q + 3'd1;
          end
        end
        kcv_pkg::S_REPORT: cnt_q <= cnt_q + 5'd1;
        kcv_pkg::S_DONE: ;
        default: ;
      endcase
    end
  end

  // state RAM: current bank read, other bank written
  always_ff @(posedge clk_i) begin
    rd_raw_q <= mem_q[{bank_q, re_idx}];
    ra_idx_q <= re_idx;
    if (mem_we) begin
      mem_q[{~bank_q, we_idx}] <= we_data;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      kcv_pkg::S_IDLE: begin
        if (in_acc) begin
          act_q  <= action_i;
          zx_q   <= meas_x_i;
          zy_q   <= meas_y_i;
          sing_q <= 1'b0;
        end
      end
      kcv_pkg::S_LOAD: begin
        if (cnt_q != 5'd0) begin
          if (!slot[3]) begin
            pc_q[slot[2:0]] <= rd_s;
          end else if (!slot[0]) begin
            m0_q <= rd_s;
          end else begin
            m1_q <= rd_s;
          end
        end
      end
      kcv_pkg::S_PREP: begin
        s00_q <= kcv_pkg::sat32({{18{pc_q[0][31]}}, pc_q[0]} + $signed({18'b0, meas_noise_q}));
        s11_q <= kcv_pkg::sat32({{18{pc_q[3][31]}}, pc_q[3]} + $signed({18'b0, meas_noise_q}));
        s01_q <= pc_q[1];
        s10_q <= pc_q[2];
        e0_q  <= kcv_pkg::sat32({{18{zx_q[31]}}, zx_q} - {{18{m0_q[31]}}, m0_q});
        e1_q  <= kcv_pkg::sat32({{18{zy_q[31]}}, zy_q} - {{18{m1_q[31]}}, m1_q});
      end
      kcv_pkg::S_JOB: begin
        if (st_q == 3'd1) begin
          tmp_q <= qv;
        end else if (st_q == 3'd2) begin
          if (jb_q == 4'd0) begin
            det_q  <= job_res;
            sing_q <= det_zero;
          end else begin
            rem_q <= num;
            dv_q  <= {d_mag, 30'b0};
            quo_q <= '0;
            neg_q <= n_cl[48] ^ det_q[48];
            ovf_q <= ovf;
          end
        end
      end
      kcv_pkg::S_DIV: begin
        if (ge) begin
          rem_q <= rem_q - dv_q[63:0];
        end
        quo_q <= qfin[29:0];
        dv_q  <= dv_q >> 1;
        if (cnt_q == kcv_pkg::DivLast) begin
          k_q[jm1[2:0]] <= kval;
        end
      end
      kcv_pkg::S_DEST: begin
        if (kcv_pkg::action_e'(act_q) == kcv_pkg::ACT_UPDATE) begin
          case (st_q)
            3'd1: acc_q <= rd_w;
            3'd3, 3'd4: acc_q <= is_mean ? acc_q + qv_w : acc_q - qv_w;
            default: ;
          endcase
        end else begin
          case (st_q)
            3'd1: acc_q <= rd_w;
            3'd2: if (msk1) acc_q <= acc_q + rd_w;
            3'd3: if (msk2) acc_q <= acc_q + rd_w;
            3'd4: acc_q <= acc_q + (msk3 ? rd_w : 50'sd0)
                           + (diag ? $signed({18'b0, proc_noise_q}) : 50'sd0);
            default: ;
          endcase
        end
      end
      kcv_pkg::S_REPORT: begin
        if (cnt_q != 5'd0) begin
          rp_q[slot[2:0]] <= rd_s;
        end
      end
      kcv_pkg::S_DONE: begin
        if (out_free) begin
          est_x_q    <= rp_q[0];
          est_y_q    <= rp_q[1];
          est_vx_q   <= rp_q[2];
          est_vy_q   <= rp_q[3];
          var_x_q    <= rp_q[4];
          var_y_q    <= rp_q[5];
          sing_out_q <= sing_q;
        end
      end
      default: ;
    endcase
  end

  `KCV_ASSERT(a_busy_after_item, (in_valid_i && !in_stall_o) |=> (state_q != kcv_pkg::S_IDLE), "item accepted but block idle")
  `KCV_ASSERT(a_fresh_on_flip, $fell(fresh_q) |-> (bank_q != $past(bank_q)), "reset view dropped without bank flip")
  `KCV_ASSERT(a_out_from_done, $rose(out_valid_o) |-> $past(state_q == kcv_pkg::S_DONE), "result raised outside done")
  `KCV_ASSERT_ALWAYS(a_div_bound, (state_q == kcv_pkg::S_DIV) |-> (cnt_q <= kcv_pkg::DivLast), "divider overran")

endmodule
`default_nettype wire
